// ===== rtl/gcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcbp_pkg
// Shared types, codes and helper functions of the GIF block structure parser.
// ----------------------------------------------------------------------------
package gcbp_pkg;

  // depth of the word queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // fixed byte values of the file format
  localparam logic [7:0]  MAGIC_G     = 8'h47;
  localparam logic [7:0]  MAGIC_I     = 8'h49;
  localparam logic [7:0]  MAGIC_F     = 8'h46;
  localparam logic [7:0]  SEP_IMAGE   = 8'h2C;
  localparam logic [7:0]  SEP_TRAILER = 8'h3B;
  localparam logic [23:0] VER_87A_STR = 24'h383761;
  localparam logic [23:0] VER_89A_STR = 24'h383961;

  // descriptor field positions
  localparam logic [3:0] CNT_SCREEN_LAST = 4'd6;
  localparam logic [3:0] CNT_IMAGE_LAST  = 4'd8;
  localparam logic [3:0] CNT_MAGIC_LAST  = 4'd2;
  localparam logic [3:0] CNT_VER_LAST    = 4'd2;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_SCREEN,
    PH_GTABLE,
    PH_SEP,
    PH_IMGDESC,
    PH_LTABLE,
    PH_CODESIZE,
    PH_BLKSIZE,
    PH_BLKDATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SCREEN,
    KIND_IMAGE,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_VERSION,
    ERR_TRUNC,
    ERR_SEP,
    ERR_TRAILER
  } err_t;

  typedef enum logic [1:0] {
    VER_87A,
    VER_89A,
    VER_OTHER
  } ver_t;

  // classified input word, as held in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       is_alpha;
    logic       is_comma;
    logic       is_semi;
    logic       is_zero;
  } word_t;

  // one result record
  typedef struct packed {
    kind_t       record_kind;
    err_t        error_code;
    ver_t        version_kind;
    logic [15:0] width_px;
    logic [15:0] height_px;
    logic [15:0] left_pos;
    logic [15:0] top_pos;
    logic [9:0]  color_table_bytes;
    logic        interlaced;
    logic [3:0]  color_resolution;
    logic [7:0]  background_index;
    logic        run_last;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC_G;
      2'd1:    m = MAGIC_I;
      2'd2:    m = MAGIC_F;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // colour table size in bytes, zero when the table flag is clear
  function automatic logic [9:0] table_bytes(input logic [7:0] flags);
    logic [3:0] sh;
    sh = {1'b0, flags[2:0]} + 4'd1;
    return flags[7] ? (10'd3 << sh) : 10'd0;
  endfunction

endpackage

// ===== rtl/gcbp_front.sv =====
// ----------------------------------------------------------------------------
// gcbp_front
// Classifies each incoming byte into the flags the parser back end needs.
// ----------------------------------------------------------------------------
module gcbp_front (
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  output gcbp_pkg::word_t word
);

  // byte classes looked at by the back end
  always_comb begin
    word.data     = data_byte;
    word.fin      = final_byte;
    word.is_alpha = gcbp_pkg::is_alpha(data_byte);
    word.is_comma = (data_byte == gcbp_pkg::SEP_IMAGE);
    word.is_semi  = (data_byte == gcbp_pkg::SEP_TRAILER);
    word.is_zero  = (data_byte == 8'h00);
  end

endmodule

// ===== rtl/gcbp_queue.sv =====
// ----------------------------------------------------------------------------
// gcbp_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module gcbp_queue #(
  parameter int DEPTH = gcbp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  gcbp_pkg::word_t push_word,
  output logic            pop_valid,
  input  logic            pop,
  output gcbp_pkg::word_t pop_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gcbp_pkg::word_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop_word   = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== rtl/gcbp_back.sv =====
// ----------------------------------------------------------------------------
// gcbp_back
// Block structure state machine: walks the file phases and loads records
// into the output register.
// ----------------------------------------------------------------------------
module gcbp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  gcbp_pkg::word_t q_word,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output gcbp_pkg::rec_t  out_rec
);

  gcbp_pkg::phase_t phase_r, phase_nxt, phase_adv;
  gcbp_pkg::err_t   err_r, err_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [9:0]       skip_r, skip_nxt;
  logic [7:0]       sub_r, sub_nxt;
  logic [23:0]      ver_r, ver_nxt, ver_sh, ver_adv;
  logic [15:0]      w_r, w_nxt, h_r, h_nxt, l_r, l_nxt, t_r, t_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [9:0]       stb_r, stb_nxt;
  logic             out_valid_r;
  gcbp_pkg::rec_t   out_rec_r;
  gcbp_pkg::rec_t   rec;
  logic             rec_vld;
  logic             raised;
  logic             fin_late;
  logic             magic_ok;
  logic             ver_good;
  logic             ver_known;
  gcbp_pkg::ver_t   vk;
  logic [9:0]       scr_tb;
  logic [9:0]       img_tb;
  logic [7:0]       b;

  assign b         = q_word.data;
  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  // byte checks
  assign fin_late = q_word.fin && (phase_r != gcbp_pkg::PH_MAGIC) &&
                    (phase_r != gcbp_pkg::PH_VERSION);
  assign magic_ok = (cnt_r <= gcbp_pkg::CNT_MAGIC_LAST) &&
                    (b == gcbp_pkg::magic_byte(cnt_r[1:0]));
  assign ver_sh   = {ver_r[15:0], b};
  assign ver_good = gcbp_pkg::is_digit(ver_sh[23:16]) &&
                    gcbp_pkg::is_digit(ver_sh[15:8]) && q_word.is_alpha;
  assign scr_tb   = gcbp_pkg::table_bytes(flags_r);
  assign img_tb   = gcbp_pkg::table_bytes(b);

  // version seen so far and whether it is already accepted
  assign ver_adv   = (q_pop && (err_r == gcbp_pkg::ERR_NONE) &&
                      (phase_r == gcbp_pkg::PH_VERSION)) ? ver_sh : ver_r;
  assign ver_known = (phase_adv != gcbp_pkg::PH_MAGIC) &&
                     (phase_adv != gcbp_pkg::PH_VERSION);
  always_comb begin
    if (!ver_known) begin
      vk = gcbp_pkg::VER_87A;
    end else if (ver_adv == gcbp_pkg::VER_87A_STR) begin
      vk = gcbp_pkg::VER_87A;
    end else if (ver_adv == gcbp_pkg::VER_89A_STR) begin
      vk = gcbp_pkg::VER_89A;
    end else begin
      vk = gcbp_pkg::VER_OTHER;
    end
  end

  // next phase
  always_comb begin
    phase_adv = phase_r;
    if (q_pop && (err_r == gcbp_pkg::ERR_NONE)) begin
      case (phase_r)
        gcbp_pkg::PH_MAGIC: begin
          if (magic_ok && (cnt_r == gcbp_pkg::CNT_MAGIC_LAST)) begin
            phase_adv = gcbp_pkg::PH_VERSION;
          end
        end
        gcbp_pkg::PH_VERSION: begin
          if ((cnt_r >= gcbp_pkg::CNT_VER_LAST) && ver_good) begin
            phase_adv = gcbp_pkg::PH_SCREEN;
          end
        end
        gcbp_pkg::PH_SCREEN: begin
          if (cnt_r >= gcbp_pkg::CNT_SCREEN_LAST) begin
            phase_adv = (scr_tb != 10'd0) ? gcbp_pkg::PH_GTABLE : gcbp_pkg::PH_SEP;
          end
        end
        gcbp_pkg::PH_GTABLE: begin
          if (skip_r <= 10'd1) begin
            phase_adv = gcbp_pkg::PH_SEP;
          end
        end
        gcbp_pkg::PH_LTABLE: begin
          if (skip_r <= 10'd1) begin
            phase_adv = gcbp_pkg::PH_CODESIZE;
          end
        end
        gcbp_pkg::PH_SEP: begin
          if (q_word.is_comma) begin
            phase_adv = gcbp_pkg::PH_IMGDESC;
          end else if (q_word.is_semi) begin
            phase_adv = gcbp_pkg::PH_DONE;
          end
        end
        gcbp_pkg::PH_IMGDESC: begin
          if (cnt_r >= gcbp_pkg::CNT_IMAGE_LAST) begin
            phase_adv = (img_tb != 10'd0) ? gcbp_pkg::PH_LTABLE : gcbp_pkg::PH_CODESIZE;
          end
        end
        gcbp_pkg::PH_CODESIZE: phase_adv = gcbp_pkg::PH_BLKSIZE;
        gcbp_pkg::PH_BLKSIZE: begin
          phase_adv = q_word.is_zero ? gcbp_pkg::PH_SEP : gcbp_pkg::PH_BLKDATA;
        end
        gcbp_pkg::PH_BLKDATA: begin
          if (sub_r <= 8'd1) begin
            phase_adv = gcbp_pkg::PH_BLKSIZE;
          end
        end
        gcbp_pkg::PH_DONE: phase_adv = gcbp_pkg::PH_DONE;
        default:           phase_adv = gcbp_pkg::PH_MAGIC;
      endcase
    end
    // the last byte of a file always returns to the start
    phase_nxt = (q_pop && q_word.fin) ? gcbp_pkg::PH_MAGIC : phase_adv;
  end

  // field accumulation, counters and record build
  always_comb begin
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    sub_nxt   = sub_r;
    ver_nxt   = ver_adv;
    w_nxt     = w_r;
    h_nxt     = h_r;
    l_nxt     = l_r;
    t_nxt     = t_r;
    flags_nxt = flags_r;
    stb_nxt   = stb_r;
    err_nxt   = err_r;
    raised    = 1'b0;
    rec_vld   = 1'b0;

    rec                   = '0;
    rec.record_kind       = gcbp_pkg::KIND_END;
    rec.error_code        = gcbp_pkg::ERR_NONE;
    rec.version_kind      = vk;
    rec.color_resolution  = 4'd1;
    rec.run_last          = 1'b1;

    if (q_pop && (err_r == gcbp_pkg::ERR_NONE)) begin
      if (fin_late) begin
        // trailer check on the last byte
        rec_vld = 1'b1;
        if (!q_word.is_semi) begin
          rec.record_kind = gcbp_pkg::KIND_ERROR;
          rec.error_code  = gcbp_pkg::ERR_TRAILER;
        end else if ((phase_r != gcbp_pkg::PH_SEP) && (phase_r != gcbp_pkg::PH_DONE)) begin
          rec.record_kind = gcbp_pkg::KIND_ERROR;
          rec.error_code  = gcbp_pkg::ERR_TRUNC;
        end
      end else begin
        case (phase_r)
          gcbp_pkg::PH_MAGIC: begin
            if (!magic_ok) begin
              raised  = 1'b1;
              err_nxt = gcbp_pkg::ERR_MAGIC;
            end else begin
              cnt_nxt = (cnt_r == gcbp_pkg::CNT_MAGIC_LAST) ? 4'd0 : cnt_r + 4'd1;
            end
          end
          gcbp_pkg::PH_VERSION: begin
            if (cnt_r >= gcbp_pkg::CNT_VER_LAST) begin
              cnt_nxt = 4'd0;
              if (!ver_good) begin
                raised  = 1'b1;
                err_nxt = gcbp_pkg::ERR_VERSION;
              end
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
          gcbp_pkg::PH_SCREEN: begin
            case (cnt_r)
              4'd0:    w_nxt = {8'h00, b};
              4'd1:    w_nxt = {b, w_r[7:0]};
              4'd2:    h_nxt = {8'h00, b};
              4'd3:    h_nxt = {b, h_r[7:0]};
              4'd4:    flags_nxt = b;
              4'd5:    l_nxt = {8'h00, b};
              default: w_nxt = w_r;
            endcase
            if (cnt_r >= gcbp_pkg::CNT_SCREEN_LAST) begin
              cnt_nxt               = 4'd0;
              stb_nxt               = scr_tb;
              l_nxt                 = 16'd0;
              rec_vld               = 1'b1;
              rec.record_kind       = gcbp_pkg::KIND_SCREEN;
              rec.width_px          = w_r;
              rec.height_px         = h_r;
              rec.color_table_bytes = scr_tb;
              rec.color_resolution  = {1'b0, flags_r[6:4]} + 4'd1;
              rec.background_index  = flags_r[7] ? l_r[7:0] : 8'h00;
              if (scr_tb != 10'd0) begin
                skip_nxt = scr_tb;
              end
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
          gcbp_pkg::PH_GTABLE, gcbp_pkg::PH_LTABLE: begin
            if (skip_r != 10'd0) begin
              skip_nxt = skip_r - 10'd1;
            end
          end
          gcbp_pkg::PH_SEP: begin
            if (q_word.is_comma) begin
              cnt_nxt = 4'd0;
            end else if (!q_word.is_semi) begin
              raised  = 1'b1;
              err_nxt = gcbp_pkg::ERR_SEP;
            end
          end
          gcbp_pkg::PH_IMGDESC: begin
            case (cnt_r)
              4'd0:    l_nxt = {8'h00, b};
              4'd1:    l_nxt = {b, l_r[7:0]};
              4'd2:    t_nxt = {8'h00, b};
              4'd3:    t_nxt = {b, t_r[7:0]};
              4'd4:    w_nxt = {8'h00, b};
              4'd5:    w_nxt = {b, w_r[7:0]};
              4'd6:    h_nxt = {8'h00, b};
              4'd7:    h_nxt = {b, h_r[7:0]};
              default: flags_nxt = b;
            endcase
            if (cnt_r >= gcbp_pkg::CNT_IMAGE_LAST) begin
              cnt_nxt               = 4'd0;
              rec_vld               = 1'b1;
              rec.record_kind       = gcbp_pkg::KIND_IMAGE;
              rec.width_px          = w_r;
              rec.height_px         = h_r;
              rec.left_pos          = l_r;
              rec.top_pos           = t_r;
              rec.color_table_bytes = img_tb;
              rec.interlaced        = b[6];
              if (img_tb != 10'd0) begin
                skip_nxt = img_tb;
              end
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
          gcbp_pkg::PH_BLKSIZE: begin
            if (!q_word.is_zero) begin
              sub_nxt = b;
            end
          end
          gcbp_pkg::PH_BLKDATA: begin
            if (sub_r != 8'd0) begin
              sub_nxt = sub_r - 8'd1;
            end
          end
          default: cnt_nxt = cnt_r;
        endcase

        // last byte inside the magic or version, or right after the version
        if (q_word.fin && !raised) begin
          raised = 1'b1;
          if (phase_adv == gcbp_pkg::PH_MAGIC) begin
            err_nxt = gcbp_pkg::ERR_MAGIC;
          end else if (phase_adv == gcbp_pkg::PH_VERSION) begin
            err_nxt = gcbp_pkg::ERR_VERSION;
          end else begin
            err_nxt = gcbp_pkg::ERR_TRAILER;
          end
        end
        if (raised) begin
          rec_vld         = 1'b1;
          rec.record_kind = gcbp_pkg::KIND_ERROR;
          rec.error_code  = err_nxt;
        end
      end
    end

    // the last byte of a file clears the parser state
    if (q_pop && q_word.fin) begin
      cnt_nxt   = 4'd0;
      skip_nxt  = 10'd0;
      sub_nxt   = 8'd0;
      ver_nxt   = 24'd0;
      w_nxt     = 16'd0;
      h_nxt     = 16'd0;
      l_nxt     = 16'd0;
      t_nxt     = 16'd0;
      flags_nxt = 8'd0;
      stb_nxt   = 10'd0;
      err_nxt   = gcbp_pkg::ERR_NONE;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gcbp_pkg::PH_MAGIC;
      err_r   <= gcbp_pkg::ERR_NONE;
      cnt_r   <= 4'd0;
      skip_r  <= 10'd0;
      sub_r   <= 8'd0;
      ver_r   <= 24'd0;
      w_r     <= 16'd0;
      h_r     <= 16'd0;
      l_r     <= 16'd0;
      t_r     <= 16'd0;
      flags_r <= 8'd0;
      stb_r   <= 10'd0;
    end else begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      sub_r   <= sub_nxt;
      ver_r   <= ver_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      l_r     <= l_nxt;
      t_r     <= t_nxt;
      flags_r <= flags_nxt;
      stb_r   <= stb_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && rec_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (q_pop && rec_vld) begin
      out_rec_r <= rec;
    end
  end

`ifndef SYNTHESIS
  // a latched error freezes the phase until the last byte of the file
  a_err_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ((err_r != gcbp_pkg::ERR_NONE) && !(q_pop && q_word.fin)) |=> $stable(phase_r))
    else $error("phase moved while an error was latched");

  // the last byte of a file leaves the parser at the start with no error
  a_fin_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_word.fin) |=> ((phase_r == gcbp_pkg::PH_MAGIC) &&
                               (err_r == gcbp_pkg::ERR_NONE) && (cnt_r == 4'd0)))
    else $error("parser not cleared after last byte");

  // an error record always carries an error code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rec_r.record_kind == gcbp_pkg::KIND_ERROR)) |->
      (out_rec_r.error_code != gcbp_pkg::ERR_NONE))
    else $error("error record without error code");

  // bytes after the trailer never give a descriptor record
  a_done_no_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (phase_r == gcbp_pkg::PH_DONE)) |=>
      !(out_valid_r && ((out_rec_r.record_kind == gcbp_pkg::KIND_SCREEN) ||
                        (out_rec_r.record_kind == gcbp_pkg::KIND_IMAGE))))
    else $error("descriptor record after trailer");

  // a word is only taken from the queue when one is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (!out_valid_r || out_ready)))
    else $error("pop without a queued word or room at the output");
`endif

endmodule

// ===== rtl/gif_container_block_parser.sv =====
// ----------------------------------------------------------------------------
// gif_container_block_parser
// GIF block structure parser: byte classifier, word queue and parser back end.
// ----------------------------------------------------------------------------
// output: each record is registered in the output register when its byte is
//   popped from the queue, which is later while other words wait ahead of it
// throughput: one byte per cycle unless a record waits at the output, set by the
//   single phase update per word in the back end; the queue takes bytes until full
// reset: synchronous, active low; clears the queue, the parse phase and the
//   output valid; the parser also returns to its start after each final byte
module gif_container_block_parser #(
  parameter int QUEUE_DEPTH = gcbp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [2:0]  out_error_code,
  output logic [1:0]  out_version_kind,
  output logic [15:0] out_width_px,
  output logic [15:0] out_height_px,
  output logic [15:0] out_left_pos,
  output logic [15:0] out_top_pos,
  output logic [9:0]  out_color_table_bytes,
  output logic        out_interlaced,
  output logic [3:0]  out_color_resolution,
  output logic [7:0]  out_background_index,
  output logic        out_run_last
);

  gcbp_pkg::word_t in_word;
  gcbp_pkg::word_t q_word;
  gcbp_pkg::rec_t  rec;
  logic            q_valid;
  logic            q_pop;

  // byte classification
  gcbp_front u_front (
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .word       (in_word)
  );

  // decoupling queue
  gcbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_word  (in_word),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_word   (q_word)
  );

  // parser and output register
  gcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (rec)
  );

  // record fields to ports
  assign out_record_kind       = rec.record_kind;
  assign out_error_code        = rec.error_code;
  assign out_version_kind      = rec.version_kind;
  assign out_width_px          = rec.width_px;
  assign out_height_px         = rec.height_px;
  assign out_left_pos          = rec.left_pos;
  assign out_top_pos           = rec.top_pos;
  assign out_color_table_bytes = rec.color_table_bytes;
  assign out_interlaced        = rec.interlaced;
  assign out_color_resolution  = rec.color_resolution;
  assign out_background_index  = rec.background_index;
  assign out_run_last          = rec.run_last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GIF block structure parser. A short table of
// hand-picked bytes comes first, then randomly built GIF files: mostly
// well-formed, some broken, some plain noise. A behavioural copy of the
// parser predicts every record, and each record from the block is compared
// field by field with the oldest prediction. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int  RANDOM_BYTES = 1700;
  localparam int  CYCLE_LIMIT  = 5000000;
  localparam int  TAIL_CYCLES  = 20;
  localparam logic [7:0] EXT_INTRO = 8'h21;

  // one row of the directed table; typed rows carry their error record
  typedef struct packed {
    logic [7:0]     data;
    logic           fin;
    logic           typed;
    gcbp_pkg::err_t code;
    gcbp_pkg::ver_t ver;
  } row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // bad magic on a zero byte, then a last byte that only clears the error
    '{8'h00, 1'b0, 1'b1, gcbp_pkg::ERR_MAGIC, gcbp_pkg::VER_87A},
    '{8'hFF, 1'b1, 1'b0, gcbp_pkg::ERR_NONE,  gcbp_pkg::VER_87A},
    // file ends inside the magic
    '{gcbp_pkg::MAGIC_G, 1'b1, 1'b1, gcbp_pkg::ERR_MAGIC, gcbp_pkg::VER_87A},
    // file ends on the byte that completes a valid version
    '{gcbp_pkg::MAGIC_G, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{gcbp_pkg::MAGIC_I, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{gcbp_pkg::MAGIC_F, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'h38, 1'b0, 1'b0, gcbp_pkg::ERR_NONE,    gcbp_pkg::VER_87A},
    '{8'h39, 1'b0, 1'b0, gcbp_pkg::ERR_NONE,    gcbp_pkg::VER_87A},
    '{8'h61, 1'b1, 1'b1, gcbp_pkg::ERR_TRAILER, gcbp_pkg::VER_89A},
    // largest screen, no global table, then a trailer where a descriptor is due
    '{gcbp_pkg::MAGIC_G, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{gcbp_pkg::MAGIC_I, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{gcbp_pkg::MAGIC_F, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'h38, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'h37, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'h61, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'hFF, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'hFF, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'hFF, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'hFF, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'h70, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'hFF, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{8'h00, 1'b0, 1'b0, gcbp_pkg::ERR_NONE, gcbp_pkg::VER_87A},
    '{gcbp_pkg::SEP_IMAGE,   1'b0, 1'b0, gcbp_pkg::ERR_NONE,  gcbp_pkg::VER_87A},
    '{gcbp_pkg::SEP_TRAILER, 1'b1, 1'b1, gcbp_pkg::ERR_TRUNC, gcbp_pkg::VER_87A}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_record_kind;
  logic [2:0]  out_error_code;
  logic [1:0]  out_version_kind;
  logic [15:0] out_width_px;
  logic [15:0] out_height_px;
  logic [15:0] out_left_pos;
  logic [15:0] out_top_pos;
  logic [9:0]  out_color_table_bytes;
  logic        out_interlaced;
  logic [3:0]  out_color_resolution;
  logic [7:0]  out_background_index;
  logic        out_run_last;

  // parser state as predicted
  gcbp_pkg::phase_t st_phase;
  logic [3:0]       st_count;
  logic [9:0]       st_skip;
  logic [7:0]       st_block_left;
  logic [23:0]      st_version;
  logic [15:0]      st_width;
  logic [15:0]      st_height;
  logic [15:0]      st_left;
  logic [15:0]      st_top;
  logic [7:0]       st_flags;
  logic [9:0]       st_screen_table;
  gcbp_pkg::err_t   st_error;

  gcbp_pkg::rec_t   expected_records[$];
  gcbp_pkg::rec_t   byte_records[$];
  logic [7:0]       file_q[$];
  logic             gap_mode;
  int               sent_bytes;
  int               mismatches;
  int               cycles;

  gif_container_block_parser u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_final_byte         (in_final_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_record_kind       (out_record_kind),
    .out_error_code        (out_error_code),
    .out_version_kind      (out_version_kind),
    .out_width_px          (out_width_px),
    .out_height_px         (out_height_px),
    .out_left_pos          (out_left_pos),
    .out_top_pos           (out_top_pos),
    .out_color_table_bytes (out_color_table_bytes),
    .out_interlaced        (out_interlaced),
    .out_color_resolution  (out_color_resolution),
    .out_background_index  (out_background_index),
    .out_run_last          (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_num_char(input logic [7:0] c);
    return (c[7:4] == 4'h3) && (c[3:0] <= 4'h9);
  endfunction

  function automatic logic is_letter_char(input logic [7:0] c);
    logic [7:0] up;
    up = c & 8'hDF;
    return (up >= 8'h41) && (up <= 8'h5A);
  endfunction

  // six bytes doubled per size step, present only with the table flag
  function automatic logic [9:0] table_size(input logic [7:0] flags);
    logic [9:0] sz;
    sz = 10'd6;
    sz = sz << flags[2:0];
    return flags[7] ? sz : 10'd0;
  endfunction

  function automatic gcbp_pkg::ver_t version_now();
    if (st_phase <= gcbp_pkg::PH_VERSION) return gcbp_pkg::VER_87A;
    if (st_version == gcbp_pkg::VER_87A_STR) return gcbp_pkg::VER_87A;
    if (st_version == gcbp_pkg::VER_89A_STR) return gcbp_pkg::VER_89A;
    return gcbp_pkg::VER_OTHER;
  endfunction

  function automatic gcbp_pkg::rec_t blank_record(input gcbp_pkg::kind_t k);
    gcbp_pkg::rec_t r;
    r = '0;
    r.record_kind = k;
    r.version_kind = version_now();
    r.color_resolution = 4'd1;
    return r;
  endfunction

  task automatic reset_model();
    st_phase = gcbp_pkg::PH_MAGIC;
    st_count = '0;
    st_skip = '0;
    st_block_left = '0;
    st_version = '0;
    st_width = '0;
    st_height = '0;
    st_left = '0;
    st_top = '0;
    st_flags = '0;
    st_screen_table = '0;
    st_error = gcbp_pkg::ERR_NONE;
  endtask

  // append one predicted record for the current byte
  task automatic add_record(input gcbp_pkg::rec_t r);
    byte_records.insert(byte_records.size(), r);
  endtask

  task automatic push_error(input gcbp_pkg::err_t code);
    gcbp_pkg::rec_t r;
    st_error = code;
    r = blank_record(gcbp_pkg::KIND_ERROR);
    r.error_code = code;
    add_record(r);
  endtask

  // records caused by one accepted byte, left in byte_records
  task automatic predict_records(input logic [7:0] b, input logic fin);
    logic [9:0] tbl;
    logic [7:0] want_magic;
    gcbp_pkg::rec_t r;
    byte_records.delete();
    // errors are sticky until the last byte of the file
    if (st_error != gcbp_pkg::ERR_NONE) begin
      if (fin) reset_model();
      return;
    end
    if (fin && st_phase >= gcbp_pkg::PH_SCREEN) begin
      // last byte past the version: trailer check only
      if (b != gcbp_pkg::SEP_TRAILER) push_error(gcbp_pkg::ERR_TRAILER);
      else if (st_phase == gcbp_pkg::PH_SEP || st_phase == gcbp_pkg::PH_DONE)
        add_record(blank_record(gcbp_pkg::KIND_END));
      else push_error(gcbp_pkg::ERR_TRUNC);
    end else begin
      case (st_phase)
        gcbp_pkg::PH_MAGIC: begin
          want_magic = (st_count == 4'd0) ? gcbp_pkg::MAGIC_G :
                       (st_count == 4'd1) ? gcbp_pkg::MAGIC_I : gcbp_pkg::MAGIC_F;
          if (b != want_magic) push_error(gcbp_pkg::ERR_MAGIC);
          else if (st_count == 4'd2) begin
            st_phase = gcbp_pkg::PH_VERSION;
            st_count = '0;
          end else st_count++;
        end
        gcbp_pkg::PH_VERSION: begin
          st_version = {st_version[15:0], b};
          if (st_count >= 4'd2) begin
            st_count = '0;
            if (is_num_char(st_version[23:16]) && is_num_char(st_version[15:8]) &&
                is_letter_char(st_version[7:0]))
              st_phase = gcbp_pkg::PH_SCREEN;
            else push_error(gcbp_pkg::ERR_VERSION);
          end else st_count++;
        end
        gcbp_pkg::PH_SCREEN: begin
          // background byte parks in the left position until the record
          case (st_count)
            4'd0: st_width = {8'h00, b};
            4'd1: st_width[15:8] = b;
            4'd2: st_height = {8'h00, b};
            4'd3: st_height[15:8] = b;
            4'd4: st_flags = b;
            4'd5: st_left = {8'h00, b};
            default: ;
          endcase
          if (st_count >= 4'd6) begin
            st_count = '0;
            st_screen_table = table_size(st_flags);
            r = blank_record(gcbp_pkg::KIND_SCREEN);
            r.width_px = st_width;
            r.height_px = st_height;
            r.color_table_bytes = st_screen_table;
            r.color_resolution = {1'b0, st_flags[6:4]} + 4'd1;
            r.background_index = st_flags[7] ? st_left[7:0] : 8'h00;
            add_record(r);
            st_left = '0;
            if (st_screen_table != '0) begin
              st_skip = st_screen_table;
              st_phase = gcbp_pkg::PH_GTABLE;
            end else st_phase = gcbp_pkg::PH_SEP;
          end else st_count++;
        end
        gcbp_pkg::PH_GTABLE, gcbp_pkg::PH_LTABLE: begin
          if (st_skip > '0) st_skip--;
          if (st_skip == '0)
            st_phase = (st_phase == gcbp_pkg::PH_GTABLE) ? gcbp_pkg::PH_SEP :
                                                           gcbp_pkg::PH_CODESIZE;
        end
        gcbp_pkg::PH_SEP: begin
          if (b == gcbp_pkg::SEP_IMAGE) begin
            st_phase = gcbp_pkg::PH_IMGDESC;
            st_count = '0;
          end else if (b == gcbp_pkg::SEP_TRAILER) st_phase = gcbp_pkg::PH_DONE;
          else push_error(gcbp_pkg::ERR_SEP);
        end
        gcbp_pkg::PH_IMGDESC: begin
          case (st_count)
            4'd0: st_left = {8'h00, b};
            4'd1: st_left[15:8] = b;
            4'd2: st_top = {8'h00, b};
            4'd3: st_top[15:8] = b;
            4'd4: st_width = {8'h00, b};
            4'd5: st_width[15:8] = b;
            4'd6: st_height = {8'h00, b};
            4'd7: st_height[15:8] = b;
            default: st_flags = b;
          endcase
          if (st_count >= 4'd8) begin
            tbl = table_size(st_flags);
            st_count = '0;
            r = blank_record(gcbp_pkg::KIND_IMAGE);
            r.width_px = st_width;
            r.height_px = st_height;
            r.left_pos = st_left;
            r.top_pos = st_top;
            r.color_table_bytes = tbl;
            r.interlaced = st_flags[6];
            add_record(r);
            if (tbl != '0) begin
              st_skip = tbl;
              st_phase = gcbp_pkg::PH_LTABLE;
            end else st_phase = gcbp_pkg::PH_CODESIZE;
          end else st_count++;
        end
        gcbp_pkg::PH_CODESIZE: st_phase = gcbp_pkg::PH_BLKSIZE;
        gcbp_pkg::PH_BLKSIZE: begin
          if (b == 8'h00) st_phase = gcbp_pkg::PH_SEP;
          else begin
            st_block_left = b;
            st_phase = gcbp_pkg::PH_BLKDATA;
          end
        end
        gcbp_pkg::PH_BLKDATA: begin
          if (st_block_left > 8'h00) st_block_left--;
          if (st_block_left == 8'h00) st_phase = gcbp_pkg::PH_BLKSIZE;
        end
        default: ;
      endcase
      // last byte inside the magic or version, or right after the version
      if (fin && st_error == gcbp_pkg::ERR_NONE) begin
        if (st_phase == gcbp_pkg::PH_MAGIC) push_error(gcbp_pkg::ERR_MAGIC);
        else if (st_phase == gcbp_pkg::PH_VERSION) push_error(gcbp_pkg::ERR_VERSION);
        else push_error(gcbp_pkg::ERR_TRAILER);
      end
    end
    if (fin) reset_model();
    if (byte_records.size() > 0) byte_records[byte_records.size() - 1].run_last = 1'b1;
  endtask

  // ---------------------------------------------------------------- handshakes

  // mostly back to back, sometimes short waits, rarely long ones
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (!gap_mode || pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one word and record its predictions once it is taken
  task automatic send_word(input logic [7:0] b, input logic fin, input logic typed,
                           input gcbp_pkg::rec_t typed_rec);
    int gap;
    int k;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    predict_records(b, fin);
    if (typed) expected_records.insert(expected_records.size(), typed_rec);
    else for (k = 0; k < byte_records.size(); k++)
      expected_records.insert(expected_records.size(), byte_records[k]);
  endtask

  // hold the sender until every predicted record is out
  task automatic wait_all_records();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  initial begin : sink_ready
    int hold;
    hold = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : record_monitor
    gcbp_pkg::rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("record_kind: expected none, got %0d", out_record_kind);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", want.record_kind, out_record_kind);
        check_field("error_code", want.error_code, out_error_code);
        check_field("version_kind", want.version_kind, out_version_kind);
        check_field("width_px", want.width_px, out_width_px);
        check_field("height_px", want.height_px, out_height_px);
        check_field("left_pos", want.left_pos, out_left_pos);
        check_field("top_pos", want.top_pos, out_top_pos);
        check_field("color_table_bytes", want.color_table_bytes, out_color_table_bytes);
        check_field("interlaced", want.interlaced, out_interlaced);
        check_field("color_resolution", want.color_resolution, out_color_resolution);
        check_field("background_index", want.background_index, out_background_index);
        check_field("run_last", want.run_last, out_run_last);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- file builder

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] wide_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // table sizes mostly small, the largest only now and then
  function automatic logic [7:0] pick_flags();
    logic [7:0] f;
    int pick;
    f = rand_byte();
    pick = $urandom_range(0, 19);
    if (pick == 0) f[2:0] = 3'd7;
    else if (pick < 3) f[2:0] = 3'($urandom_range(3, 6));
    else f[2:0] = 3'($urandom_range(0, 2));
    return f;
  endfunction

  task automatic add_file_byte(input logic [7:0] v);
    file_q.insert(file_q.size(), v);
  endtask

  task automatic push_le16(input logic [15:0] v);
    add_file_byte(v[7:0]);
    add_file_byte(v[15:8]);
  endtask

  task automatic push_table(input logic [7:0] flags);
    repeat (table_size(flags)) add_file_byte(rand_byte());
  endtask

  task automatic build_file();
    logic [23:0] ver;
    logic [7:0]  f;
    logic [7:0]  sep;
    int          pick;
    int          sz;
    int          keep;
    file_q.delete();
    // plain noise, often with a plausible first byte
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) add_file_byte(rand_byte());
      if ($urandom_range(0, 1)) file_q[0] = gcbp_pkg::MAGIC_G;
      return;
    end
    add_file_byte(gcbp_pkg::MAGIC_G);
    add_file_byte(gcbp_pkg::MAGIC_I);
    add_file_byte(gcbp_pkg::MAGIC_F);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ver = gcbp_pkg::VER_87A_STR;
      4, 5, 6, 7: ver = gcbp_pkg::VER_89A_STR;
      8: ver = {8'h30 + 8'($urandom_range(0, 9)), 8'h30 + 8'($urandom_range(0, 9)),
                ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25))};
      default: ver = {rand_byte(), rand_byte(), rand_byte()};
    endcase
    add_file_byte(ver[23:16]);
    add_file_byte(ver[15:8]);
    add_file_byte(ver[7:0]);
    // screen descriptor and global table
    push_le16(wide_value());
    push_le16(wide_value());
    f = pick_flags();
    add_file_byte(f);
    add_file_byte(rand_byte());
    add_file_byte(rand_byte());
    push_table(f);
    // frames
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 19);
      sep = (pick == 0) ? EXT_INTRO : (pick == 1) ? rand_byte() : gcbp_pkg::SEP_IMAGE;
      add_file_byte(sep);
      push_le16(wide_value());
      push_le16(wide_value());
      push_le16(wide_value());
      push_le16(wide_value());
      f = pick_flags();
      add_file_byte(f);
      push_table(f);
      add_file_byte(rand_byte());
      repeat ($urandom_range(0, 3)) begin
        sz = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
        add_file_byte(8'(sz));
        repeat (sz) add_file_byte(rand_byte());
      end
      add_file_byte(8'h00);
    end
    add_file_byte(($urandom_range(0, 9) != 0) ? gcbp_pkg::SEP_TRAILER : rand_byte());
    // junk after the trailer, ending on a trailer or not
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) add_file_byte(rand_byte());
      add_file_byte($urandom_range(0, 1) ? gcbp_pkg::SEP_TRAILER : rand_byte());
    end
    // damage: one byte overwritten, or the file cut short
    if ($urandom_range(0, 9) == 0) file_q[$urandom_range(0, file_q.size() - 1)] = rand_byte();
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    gcbp_pkg::rec_t typed_rec;
    int             i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_final_byte = 1'b0;
    gap_mode = 1'b1;
    sent_bytes = 0;
    mismatches = 0;
    cycles = 0;
    reset_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      typed_rec = '0;
      typed_rec.record_kind = gcbp_pkg::KIND_ERROR;
      typed_rec.error_code = DIRECTED[i].code;
      typed_rec.version_kind = DIRECTED[i].ver;
      typed_rec.color_resolution = 4'd1;
      typed_rec.run_last = 1'b1;
      send_word(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].typed, typed_rec);
    end
    wait_all_records();

    // random files, some with no idling at all
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      gap_mode = ($urandom_range(0, 3) != 0);
      build_file();
      for (i = 0; i < file_q.size(); i++)
        send_word(file_q[i], i == file_q.size() - 1, 1'b0, '0);
      if ($urandom_range(0, 9) == 0) wait_all_records();
    end

    wait_all_records();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== gif_container_block_parser.f =====
rtl/gcbp_pkg.sv
rtl/gcbp_front.sv
rtl/gcbp_queue.sv
rtl/gcbp_back.sv
rtl/gif_container_block_parser.sv
verif/tb.sv
